// ===== sv/hcbp_pkg.sv =====
// Shared types and constants for the Huffman code bit packer.
// Used by the front end, the job queue, the back end and the top level.
package hcbp_pkg;

  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int PEND_W  = 7;
  localparam int WORK_W  = CODE_W + PEND_W;
  localparam int TABLE_DEPTH = 256;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // One unit of work handed from the front end to the back end.
  typedef struct packed {
    logic              is_flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } job_t;

  // Handshake between a producer and the job queue.
  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

endpackage

// ===== sv/huffman_code_bit_packer_top.sv =====
// Top level of the Huffman code bit packer.
// Instantiates hcbp_front, hcbp_queue and hcbp_back; uses hcbp_pkg.
//
// Usage: the input channel (in_valid, in_stall) carries one item per
// handshake: kind 0 loads a code table entry, kind 1 encodes data_byte,
// kind 2 flushes the stream and kind 3 is ignored. The output channel
// (out_valid, out_stall) carries packed bytes, earliest bit in bit 7, and
// the pad report of a flush; last marks the final result of an item.
// A data item yields one result per whole byte that its code completes,
// up to four for a 32-bit code; an absent symbol yields none.
// An accepted item passes through the table read register, the job queue,
// the back-end state and work registers and the output register before its
// first result appears. The back end takes a job from the queue only while
// idle, then emits one result per cycle while the receiver does not stall.
// A flush emits the pending bits as a byte, if any, then the pad report.
// Loads stay in the front end. Reset clears the pending bits and marks every
// table entry absent through per-entry valid flags, so the block accepts
// items as soon as reset is released. When the receiver stalls, the result
// is held in the output register, the back end waits, the two-entry queue
// fills and then the input channel stalls.
module huffman_code_bit_packer_top import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  table_index,
  input  logic [31:0] entry_code,
  input  logic [5:0]  entry_length,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        is_pad_report,
  output logic [2:0]  pad_bits,
  output logic        last
);

  push_t q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  job_t  q_head;

  hcbp_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .table_index  (table_index),
    .entry_code   (entry_code),
    .entry_length (entry_length),
    .data_byte    (data_byte),
    .q_full       (q_full),
    .q_push       (q_push)
  );

  hcbp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_head  (q_head)
  );

  hcbp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .is_pad_report (is_pad_report),
    .pad_bits      (pad_bits),
    .last          (last)
  );

endmodule

// ===== sv/hcbp_front.sv =====
// Front end of the bit packer: accepts items, owns the code table and turns
// data and flush items into jobs. Depends on hcbp_pkg.
module hcbp_front import hcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        kind,
  input  logic [7:0]        table_index,
  input  logic [CODE_W-1:0] entry_code,
  input  logic [LEN_W-1:0]  entry_length,
  input  logic [7:0]        data_byte,
  input  logic              q_full,
  output push_t             q_push
);

  localparam int CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [CODE_W+LEN_W-1:0] table_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]  entry_valid;

  logic                    s1_valid;
  logic                    s1_flush;
  logic [CODE_W+LEN_W-1:0] rd_data;
  logic                    rd_valid;

  logic                    accept;
  logic [LEN_W-1:0]        len_sat;
  logic [CODE_W-1:0]       code_masked;
  logic [LEN_W-1:0]        rd_len;

  assign in_stall = s1_valid && q_full;
  assign accept   = in_valid && !in_stall;

  // Lengths above the cap saturate; code bits above the length are dropped.
  assign len_sat     = (entry_length > LEN_W'(CAP)) ? LEN_W'(CAP) : entry_length;
  assign code_masked = entry_code & ~({CODE_W{1'b1}} << len_sat);

  // The table is written and read on the accept edge, so a lookup always
  // sees a load accepted on an earlier edge.
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_LOAD) begin
      table_mem[table_index] <= {code_masked, len_sat};
    end
    if (accept) begin
      rd_data <= table_mem[data_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
      s1_valid    <= 1'b0;
      s1_flush    <= 1'b0;
    end else begin
      if (accept && kind == KIND_LOAD) begin
        entry_valid[table_index] <= 1'b1;
      end
      if (accept) begin
        rd_valid <= entry_valid[data_byte];
        s1_valid <= (kind == KIND_DATA) || (kind == KIND_FLUSH);
        s1_flush <= (kind == KIND_FLUSH);
      end else if (s1_valid && !q_full) begin
        s1_valid <= 1'b0;
      end
    end
  end

  assign rd_len = rd_valid ? rd_data[LEN_W-1:0] : '0;

  // Absent symbols are dropped here and never reach the back end.
  assign q_push.push         = s1_valid && !q_full && (s1_flush || rd_len != '0);
  assign q_push.job.is_flush = s1_flush;
  assign q_push.job.code     = rd_data[CODE_W+LEN_W-1:LEN_W];
  assign q_push.job.len      = rd_len;

endmodule

// ===== sv/hcbp_queue.sv =====
// Two-entry job queue that decouples the front end from the back end.
// Depends on hcbp_pkg.
module hcbp_queue import hcbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  push_t q_push,
  output logic  q_full,
  output logic  q_empty,
  input  logic  q_pop,
  output job_t  q_head
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      slots[wr_ptr] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({q_push.push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/hcbp_back.sv =====
// Back end of the bit packer: merges code bits with the pending bits and
// emits one output byte or pad report per cycle while the receiver does not stall. Depends on hcbp_pkg.
module hcbp_back import hcbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  job_t       q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_pad_report,
  output logic [2:0] pad_bits,
  output logic       last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DATA,
    ST_FLUSH_BYTE,
    ST_FLUSH_PAD
  } state_t;

  state_t              state;
  logic [PEND_W-1:0]   pend_la;     // pending bits, left aligned, zeros below
  logic [2:0]          pend_count;
  logic [WORK_W-1:0]   work;
  logic [LEN_W-1:0]    total;
  logic [2:0]          pad;

  logic                slot_free;
  logic                emit;
  logic [CODE_W-1:0]   code_la;
  logic [WORK_W-1:0]   merged;
  logic [LEN_W-1:0]    total_new;
  logic [WORK_W-1:0]   work_shift;

  assign slot_free = !out_valid || !out_stall;
  assign emit      = slot_free && (state == ST_DATA || state == ST_FLUSH_BYTE ||
                                   state == ST_FLUSH_PAD);
  assign q_pop     = (state == ST_IDLE) && !q_empty;

  assign code_la    = q_head.code << (LEN_W'(CODE_W) - q_head.len);
  assign merged     = {pend_la, {CODE_W{1'b0}}} | ({code_la, {PEND_W{1'b0}}} >> pend_count);
  assign total_new  = LEN_W'(pend_count) + q_head.len;
  assign work_shift = work << 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      pend_la    <= '0;
      pend_count <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_head.is_flush) begin
              pad   <= 3'd0 - pend_count;
              state <= (pend_count != 3'd0) ? ST_FLUSH_BYTE : ST_FLUSH_PAD;
            end else if (total_new < LEN_W'(8)) begin
              pend_la    <= merged[WORK_W-1 -: PEND_W];
              pend_count <= total_new[2:0];
            end else begin
              work  <= merged;
              total <= total_new;
              state <= ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (slot_free) begin
            out_byte      <= work[WORK_W-1 -: 8];
            is_pad_report <= 1'b0;
            pad_bits      <= 3'd0;
            last          <= (total < LEN_W'(16));
            work          <= work_shift;
            total         <= total - LEN_W'(8);
            if (total < LEN_W'(16)) begin
              pend_la    <= work_shift[WORK_W-1 -: PEND_W];
              pend_count <= total[2:0];
              state      <= ST_IDLE;
            end
          end
        end
        ST_FLUSH_BYTE: begin
          if (slot_free) begin
            out_byte      <= {pend_la, 1'b0};
            is_pad_report <= 1'b0;
            pad_bits      <= 3'd0;
            last          <= 1'b0;
            state         <= ST_FLUSH_PAD;
          end
        end
        ST_FLUSH_PAD: begin
          if (slot_free) begin
            out_byte      <= 8'd0;
            is_pad_report <= 1'b1;
            pad_bits      <= pad;
            last          <= 1'b1;
            pend_la       <= '0;
            pend_count    <= '0;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
